@@ rtl/rbd_pkg.sv @@
package rbd_pkg;

    // Fixed field widths of the command and response beats.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned ERR_W  = 2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ERR_W-1:0]         t_err;

    // Operation codes.
    localparam t_op OP_INS_FRONT = 2'd0;
    localparam t_op OP_INS_REAR  = 2'd1;
    localparam t_op OP_REM_FRONT = 2'd2;
    localparam t_op OP_REM_REAR  = 2'd3;

    // Error codes.
    localparam t_err ERR_NONE  = 2'd0;
    localparam t_err ERR_FULL  = 2'd1;
    localparam t_err ERR_EMPTY = 2'd2;

    // Value reported for front and rear when the deque is empty.
    localparam t_data EMPTY_VALUE = '1;

endpackage

@@ rtl/rbd_if.sv @@
// Command channel: one deque operation per beat.
interface rbd_cmd_if;
    logic           valid;
    logic           ready;
    rbd_pkg::t_op   operation;
    rbd_pkg::t_data value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// Response channel: deque status after each operation.
interface rbd_rsp_if;
    logic           valid;
    logic           ready;
    rbd_pkg::t_data front_value;
    rbd_pkg::t_data rear_value;
    rbd_pkg::t_cnt  occupancy;
    rbd_pkg::t_err  error_code;
    logic           is_empty;
    logic           is_full;

    modport source (
        output valid, output front_value, output rear_value, output occupancy,
        output error_code, output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input front_value, input rear_value, input occupancy,
        input error_code, input is_empty, input is_full, output ready
    );
endinterface

@@ rtl/ring_buffer_deque.sv @@
// Inserts, rejected operations and removals that empty the deque give their response
// beat in the cycle after the command beat; a removal that leaves elements reads the
// new end via the registered memory read port, then the response register. One
// command per cycle while responses are taken; such a removal holds off the following
// command until its read on the single read port completes. Reset (synchronous)
// empties the deque and sets the capacity to its maximum; the ring memory is not cleared.
module ring_buffer_deque #(
    parameter int unsigned MAX_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rbd_pkg::CNT_W-1:0]  i_cfg_wdata,
    rbd_cmd_if.sink                    i_cmd,
    rbd_rsp_if.source                  o_rsp
);

    localparam int unsigned IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned CAP_LIM = (MAX_DEPTH < 31) ? MAX_DEPTH : 31;
    localparam rbd_pkg::t_cnt CAP_MAX = rbd_pkg::CNT_W'(CAP_LIM);

    typedef logic [IDX_W-1:0] t_idx;
    typedef enum logic {ST_IDLE, ST_READ} t_state;

    // Ring memory, one write and one registered read port.
    rbd_pkg::t_data mem [MAX_DEPTH];
    logic           w_mem_we;
    t_idx           w_mem_waddr;
    rbd_pkg::t_data w_mem_wdata;
    t_idx           w_mem_raddr;
    rbd_pkg::t_data r_mem_rdata;

    // Control and cached end values.
    t_state          r_state,  n_state;
    rbd_pkg::t_cnt   r_cap,    n_cap;
    t_idx            r_head,   n_head;
    t_idx            r_tail,   n_tail;
    rbd_pkg::t_cnt   r_count,  n_count;
    rbd_pkg::t_data  r_front,  n_front;
    rbd_pkg::t_data  r_rear,   n_rear;
    logic            r_rd_front, n_rd_front;

    // Response register.
    logic            r_out_valid, n_out_valid;
    rbd_pkg::t_data  r_out_front, n_out_front;
    rbd_pkg::t_data  r_out_rear,  n_out_rear;
    rbd_pkg::t_cnt   r_out_count, n_out_count;
    rbd_pkg::t_err   r_out_err,   n_out_err;
    logic            r_out_empty, n_out_empty;
    logic            r_out_full,  n_out_full;

    rbd_pkg::t_cnt   w_cap;
    t_idx            w_cap_last;
    t_idx            w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic            w_cmd_fire;
    logic            w_load_out;
    rbd_pkg::t_err   w_err;

    // Effective capacity, clamped to one and to the smaller of the built depth and 31.
    always_comb begin
        if (r_cap == '0) begin
            w_cap = rbd_pkg::CNT_W'(1);
        end else if (r_cap > CAP_MAX) begin
            w_cap = CAP_MAX;
        end else begin
            w_cap = r_cap;
        end
    end

    assign w_cap_last = IDX_W'(w_cap - rbd_pkg::CNT_W'(1));
    assign w_head_inc = (r_head == w_cap_last) ? '0 : r_head + t_idx'(1);
    assign w_head_dec = (r_head == '0) ? w_cap_last : r_head - t_idx'(1);
    assign w_tail_inc = (r_tail == w_cap_last) ? '0 : r_tail + t_idx'(1);
    assign w_tail_dec = (r_tail == '0) ? w_cap_last : r_tail - t_idx'(1);

    // A command is taken when no read is pending and the response slot frees up.
    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_cmd_fire  = i_cmd.valid && i_cmd.ready;

    // Next-state logic for pointers, cached ends, memory access and response.
    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_rear      = r_rear;
        n_rd_front  = r_rd_front;
        w_mem_we    = 1'b0;
        w_mem_waddr = '0;
        w_mem_wdata = i_cmd.value;
        w_mem_raddr = w_head_inc;
        w_load_out  = 1'b0;
        w_err       = rbd_pkg::ERR_NONE;

        if (w_cmd_fire) begin
            if (!i_cmd.operation[1]) begin
                // Insert at either end.
                if (r_count >= w_cap) begin
                    w_err      = rbd_pkg::ERR_FULL;
                    w_load_out = 1'b1;
                end else begin
                    w_mem_we   = 1'b1;
                    w_load_out = 1'b1;
                    n_count    = r_count + rbd_pkg::CNT_W'(1);
                    if (r_count == '0) begin
                        n_head      = '0;
                        n_tail      = '0;
                        w_mem_waddr = '0;
                        n_front     = i_cmd.value;
                        n_rear      = i_cmd.value;
                    end else if (i_cmd.operation == rbd_pkg::OP_INS_FRONT) begin
                        n_head      = w_head_dec;
                        w_mem_waddr = w_head_dec;
                        n_front     = i_cmd.value;
                    end else begin
                        n_tail      = w_tail_inc;
                        w_mem_waddr = w_tail_inc;
                        n_rear      = i_cmd.value;
                    end
                end
            end else begin
                // Removal at either end.
                if (r_count == '0) begin
                    w_err      = rbd_pkg::ERR_EMPTY;
                    w_load_out = 1'b1;
                end else begin
                    n_count = r_count - rbd_pkg::CNT_W'(1);
                    if (r_count == rbd_pkg::CNT_W'(1)) begin
                        n_head     = '0;
                        n_tail     = '0;
                        w_load_out = 1'b1;
                    end else if (i_cmd.operation == rbd_pkg::OP_REM_FRONT) begin
                        n_head      = w_head_inc;
                        w_mem_raddr = w_head_inc;
                        n_rd_front  = 1'b1;
                        n_state     = ST_READ;
                    end else begin
                        n_tail      = w_tail_dec;
                        w_mem_raddr = w_tail_dec;
                        n_rd_front  = 1'b0;
                        n_state     = ST_READ;
                    end
                end
            end
        end else if (r_state == ST_READ) begin
            // The new end value arrives from memory.
            if (r_rd_front) begin
                n_front = r_mem_rdata;
            end else begin
                n_rear = r_mem_rdata;
            end
            w_load_out = 1'b1;
            n_state    = ST_IDLE;
        end

        // A capacity write empties the deque.
        if (i_cfg_we) begin
            n_cap   = i_cfg_wdata;
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    // Response register load and drain.
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_front = r_out_front;
        n_out_rear  = r_out_rear;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        n_out_empty = r_out_empty;
        n_out_full  = r_out_full;
        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_out_front = (n_count == '0) ? rbd_pkg::EMPTY_VALUE : n_front;
            n_out_rear  = (n_count == '0) ? rbd_pkg::EMPTY_VALUE : n_rear;
            n_out_count = n_count;
            n_out_err   = w_err;
            n_out_empty = (n_count == '0);
            n_out_full  = (n_count == w_cap);
        end
    end

    // State, pointers and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_MAX;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rd_front  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rd_front  <= n_rd_front;
            r_out_valid <= n_out_valid;
        end
        r_front     <= n_front;
        r_rear      <= n_rear;
        r_out_front <= n_out_front;
        r_out_rear  <= n_out_rear;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
        r_out_empty <= n_out_empty;
        r_out_full  <= n_out_full;
    end

    // Ring memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_mem_rdata <= mem[w_mem_raddr];
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.rear_value  = r_out_rear;
    assign o_rsp.occupancy   = r_out_count;
    assign o_rsp.error_code  = r_out_err;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;

endmodule
